[rtl/ptc_pkg.sv]
`timescale 1ns / 1ps
package ptc_pkg;

   localparam int AdcWidth = 20;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 64;
   localparam int DivSteps = 64;

   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_CAL = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_CAL_A = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_CAL_B = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_CAL_C = 2'd3;

   // Calibration coefficients, already extended: t1 to t3 to 32 bits, p1 to p9 to 64 bits.
   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [63:0] p1;
      logic [63:0] p2;
      logic [63:0] p3;
      logic [63:0] p4;
      logic [63:0] p5;
      logic [63:0] p6;
      logic [63:0] p7;
      logic [63:0] p8;
      logic [63:0] p9;
   } coef_type;

   // Operands handed from the front end to the divider.
   typedef struct packed {
      logic        valid;
      logic [31:0] temperature;
      logic [31:0] fine_temp;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   // Quotient and pass-through fields from the divider.
   typedef struct packed {
      logic        valid;
      logic [31:0] temperature;
      logic [31:0] fine_temp;
      logic [63:0] quotient;
      logic        divisor_zero;
   } div_rsp_type;

   function automatic logic [63:0] sext16(input logic [15:0] f);
      sext16 = {{48{f[15]}}, f};
   endfunction

   // 64x64 wrapping product built from 32-bit partial products.
   function automatic logic [63:0] mul64_lo(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ll;
      logic [31:0] lh;
      logic [31:0] hl;
      ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh = a[31:0] * b[63:32];
      hl = a[63:32] * b[31:0];
      mul64_lo = ll + {lh + hl, 32'd0};
   endfunction

endpackage

[rtl/ptc_front.sv]
`timescale 1ns / 1ps
// Temperature path and pressure-path operands up to the divider inputs.
// Seven register stages, at most one multiplication level per stage.
module ptc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [ptc_pkg::AdcWidth-1:0] adc_temp,
   input  logic [ptc_pkg::AdcWidth-1:0] adc_press,
   input  ptc_pkg::coef_type          coef,
   output ptc_pkg::div_req_type       div_req
);

   // Stage 1: raw differences.
   logic        s1_valid_ff;
   logic [31:0] s1_x_ff, s1_d_ff;
   logic [ptc_pkg::AdcWidth-1:0] s1_adcp_ff;
   // Stage 2: first products.
   logic        s2_valid_ff;
   logic [31:0] s2_a_ff, s2_dd_ff;
   logic [ptc_pkg::AdcWidth-1:0] s2_adcp_ff;
   // Stage 3: fine temperature terms.
   logic        s3_valid_ff;
   logic [31:0] s3_a_ff, s3_b_ff;
   logic [ptc_pkg::AdcWidth-1:0] s3_adcp_ff;
   // Stage 4: fine temperature, v1.
   logic        s4_valid_ff;
   logic [31:0] s4_fine_ff, s4_temp_ff;
   logic [63:0] s4_v1_ff;
   logic [ptc_pkg::AdcWidth-1:0] s4_adcp_ff;
   // Stage 5: v1 squared, v1*p5, v1*p2.
   logic        s5_valid_ff;
   logic [31:0] s5_fine_ff, s5_temp_ff;
   logic [63:0] s5_sq_ff, s5_v1p5_ff, s5_v1p2_ff;
   logic [ptc_pkg::AdcWidth-1:0] s5_adcp_ff;
   // Stage 6: v2 and partial v1.
   logic        s6_valid_ff;
   logic [31:0] s6_fine_ff, s6_temp_ff;
   logic [63:0] s6_v2_ff, s6_v1_ff;
   logic [ptc_pkg::AdcWidth-1:0] s6_adcp_ff;
   // Stage 7: divisor and dividend.
   ptc_pkg::div_req_type s7_ff;

   logic [31:0] s2_a_in, s2_dd_in, s3_b_in, s4_fine_in, s4_temp_in;
   logic [63:0] s4_v1_in, s6_v2_in, s6_v1_in, s7_div_in, s7_num_in;
   logic [31:0] prod_a, prod_b, prod_t;
   logic [63:0] sq_p6, sq_p3, v1_mid, p_num;

   always_comb begin
      prod_a = s1_x_ff * coef.t2;
      s2_a_in = 32'($signed(prod_a) >>> 11);
      s2_dd_in = s1_d_ff * s1_d_ff;
      prod_b = 32'($signed(s2_dd_ff) >>> 12) * coef.t3;
      s3_b_in = 32'($signed(prod_b) >>> 14);
      s4_fine_in = s3_a_ff + s3_b_ff;
      prod_t = s4_fine_in * 32'd5 + 32'd128;
      s4_temp_in = 32'($signed(prod_t) >>> 8);
      s4_v1_in = {{32{s4_fine_in[31]}}, s4_fine_in} - 64'd128000;
      sq_p6 = ptc_pkg::mul64_lo(s5_sq_ff, coef.p6);
      sq_p3 = ptc_pkg::mul64_lo(s5_sq_ff, coef.p3);
      s6_v2_in = sq_p6 + (s5_v1p5_ff << 17) + (coef.p4 << 35);
      s6_v1_in = 64'($signed(sq_p3) >>> 8) + (s5_v1p2_ff << 12);
      v1_mid = ptc_pkg::mul64_lo((64'd1 << 47) + s6_v1_ff, coef.p1);
      s7_div_in = 64'($signed(v1_mid) >>> 33);
      p_num = 64'd1048576 - {44'd0, s6_adcp_ff};
      s7_num_in = ptc_pkg::mul64_lo((p_num << 31) - s6_v2_ff, 64'd3125);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_ff.valid <= s6_valid_ff;
      end
      s1_x_ff <= {15'd0, adc_temp[19:3]} - (coef.t1 << 1);
      s1_d_ff <= {16'd0, adc_temp[19:4]} - coef.t1;
      s1_adcp_ff <= adc_press;
      s2_a_ff <= s2_a_in;
      s2_dd_ff <= s2_dd_in;
      s2_adcp_ff <= s1_adcp_ff;
      s3_a_ff <= s2_a_ff;
      s3_b_ff <= s3_b_in;
      s3_adcp_ff <= s2_adcp_ff;
      s4_fine_ff <= s4_fine_in;
      s4_temp_ff <= s4_temp_in;
      s4_v1_ff <= s4_v1_in;
      s4_adcp_ff <= s3_adcp_ff;
      s5_fine_ff <= s4_fine_ff;
      s5_temp_ff <= s4_temp_ff;
      s5_sq_ff <= ptc_pkg::mul64_lo(s4_v1_ff, s4_v1_ff);
      s5_v1p5_ff <= ptc_pkg::mul64_lo(s4_v1_ff, coef.p5);
      s5_v1p2_ff <= ptc_pkg::mul64_lo(s4_v1_ff, coef.p2);
      s5_adcp_ff <= s4_adcp_ff;
      s6_fine_ff <= s5_fine_ff;
      s6_temp_ff <= s5_temp_ff;
      s6_v2_ff <= s6_v2_in;
      s6_v1_ff <= s6_v1_in;
      s6_adcp_ff <= s5_adcp_ff;
      s7_ff.fine_temp <= s6_fine_ff;
      s7_ff.temperature <= s6_temp_ff;
      s7_ff.divisor <= s7_div_in;
      s7_ff.dividend <= s7_num_in;
   end

   assign div_req = s7_ff;

endmodule

[rtl/ptc_div.sv]
`timescale 1ns / 1ps
// Pipelined signed 64-bit divider, one restoring quotient bit per stage.
module ptc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ptc_pkg::div_req_type div_req,
   output ptc_pkg::div_rsp_type div_rsp
);

   localparam int N = ptc_pkg::DivSteps;

   logic [N:0]      valid_ff;
   logic [63:0]     rem_ff [N+1];
   logic [63:0]     quo_ff [N+1];
   logic [63:0]     den_ff [N+1];
   logic [N:0]      neg_ff;
   logic [N:0]      zero_ff;
   logic [31:0]     temp_ff [N+1];
   logic [31:0]     fine_ff [N+1];

   logic [63:0] mag_num, mag_den;

   always_comb begin
      mag_num = div_req.dividend[63] ? 64'd0 - div_req.dividend : div_req.dividend;
      mag_den = div_req.divisor[63] ? 64'd0 - div_req.divisor : div_req.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else valid_ff[0] <= div_req.valid;
      rem_ff[0] <= 64'd0;
      quo_ff[0] <= mag_num;
      den_ff[0] <= mag_den;
      neg_ff[0] <= div_req.dividend[63] ^ div_req.divisor[63];
      zero_ff[0] <= (div_req.divisor == 64'd0);
      temp_ff[0] <= div_req.temperature;
      fine_ff[0] <= div_req.fine_temp;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      logic [64:0] trial;
      logic [63:0] shifted;
      always_comb begin
         shifted = {rem_ff[i][62:0], quo_ff[i][63]};
         trial = {rem_ff[i][63], shifted} - {1'b0, den_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else valid_ff[i+1] <= valid_ff[i];
         if (!trial[64]) begin
            rem_ff[i+1] <= trial[63:0];
            quo_ff[i+1] <= {quo_ff[i][62:0], 1'b1};
         end else begin
            rem_ff[i+1] <= shifted;
            quo_ff[i+1] <= {quo_ff[i][62:0], 1'b0};
         end
         den_ff[i+1] <= den_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         zero_ff[i+1] <= zero_ff[i];
         temp_ff[i+1] <= temp_ff[i];
         fine_ff[i+1] <= fine_ff[i];
      end
   end

   always_comb begin
      div_rsp.valid = valid_ff[N];
      div_rsp.temperature = temp_ff[N];
      div_rsp.fine_temp = fine_ff[N];
      div_rsp.quotient = neg_ff[N] ? 64'd0 - quo_ff[N] : quo_ff[N];
      div_rsp.divisor_zero = zero_ff[N];
   end

endmodule

[rtl/ptc_back.sv]
`timescale 1ns / 1ps
// Pressure correction after the division, three register stages.
module ptc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ptc_pkg::coef_type    coef,
   input  ptc_pkg::div_rsp_type div_rsp,
   output logic                 out_valid,
   output logic [31:0]          temperature,
   output logic [31:0]          fine_temp,
   output logic [31:0]          pressure,
   output logic                 divisor_zero
);

   logic        b1_valid_ff, b2_valid_ff, b3_valid_ff;
   logic [31:0] b1_temp_ff, b2_temp_ff, b3_temp_ff;
   logic [31:0] b1_fine_ff, b2_fine_ff, b3_fine_ff;
   logic        b1_zero_ff, b2_zero_ff, b3_zero_ff;
   logic [63:0] b1_p_ff, b1_ps_ff, b1_p9ps_ff, b1_p8p_ff;
   logic [63:0] b2_p_ff, b2_c1_ff, b2_c2_ff;
   logic [31:0] b3_press_ff;

   logic [63:0] ps_in, c1_raw, c2_in, sum, press_in;

   always_comb begin
      ps_in = 64'($signed(div_rsp.quotient) >>> 13);
      c1_raw = ptc_pkg::mul64_lo(b1_p9ps_ff, b1_ps_ff);
      c2_in = 64'($signed(b1_p8p_ff) >>> 19);
      sum = b2_p_ff + b2_c1_ff + b2_c2_ff;
      press_in = 64'($signed(sum) >>> 8) + (coef.p7 << 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= div_rsp.valid;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
      b1_temp_ff <= div_rsp.temperature;
      b1_fine_ff <= div_rsp.fine_temp;
      b1_zero_ff <= div_rsp.divisor_zero;
      b1_p_ff <= div_rsp.quotient;
      b1_ps_ff <= ps_in;
      b1_p9ps_ff <= ptc_pkg::mul64_lo(coef.p9, ps_in);
      b1_p8p_ff <= ptc_pkg::mul64_lo(coef.p8, div_rsp.quotient);
      b2_temp_ff <= b1_temp_ff;
      b2_fine_ff <= b1_fine_ff;
      b2_zero_ff <= b1_zero_ff;
      b2_p_ff <= b1_p_ff;
      b2_c1_ff <= 64'($signed(c1_raw) >>> 25);
      b2_c2_ff <= c2_in;
      b3_temp_ff <= b2_temp_ff;
      b3_fine_ff <= b2_fine_ff;
      b3_zero_ff <= b2_zero_ff;
      b3_press_ff <= b2_zero_ff ? 32'd0 : press_in[31:0];
   end

   assign out_valid = b3_valid_ff;
   assign temperature = b3_temp_ff;
   assign fine_temp = b3_fine_ff;
   assign pressure = b3_press_ff;
   assign divisor_zero = b3_zero_ff;

endmodule

[rtl/pressure_temperature_compensation.sv]
`timescale 1ns / 1ps
// Compensates one raw temperature and pressure pair per transaction. A
// transaction is taken at every clock edge where start is high and busy is low;
// busy is always low, so a new transaction may enter every cycle. Each result
// appears with rsp_valid high for exactly one cycle, and results leave in the
// order their transactions entered. The receiver cannot stall the block, so it
// must take every result as it appears. A transaction passes seven front
// stages, the 64-bit signed divider, which resolves one quotient bit per stage,
// and three back stages. Calibration registers are written through the csr_
// port and must only change while no transaction is in flight; the two-bit
// index selects one of the four registers.
module pressure_temperature_compensation (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [19:0]              req_adc_temp,
   input  logic [19:0]              req_adc_press,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [63:0]              csr_data,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_temperature,
   output logic signed [31:0]       rsp_fine_temp,
   output logic [31:0]              rsp_pressure,
   output logic                     rsp_divisor_zero
);

   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff, press_cal_b_ff;
   logic [15:0] press_cal_c_ff;
   ptc_pkg::coef_type coef;
   ptc_pkg::div_req_type div_req;
   ptc_pkg::div_rsp_type div_rsp;
   logic accept;
   logic [31:0] temp_w, fine_w;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         press_cal_c_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ptc_pkg::CSR_TEMP_CAL: temp_cal_ff <= csr_data[47:0];
            ptc_pkg::CSR_PRESS_CAL_A: press_cal_a_ff <= csr_data;
            ptc_pkg::CSR_PRESS_CAL_B: press_cal_b_ff <= csr_data;
            ptc_pkg::CSR_PRESS_CAL_C: press_cal_c_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Unpack the coefficients; t1 and p1 are zero-extended, the rest sign-extended.
   always_comb begin
      coef.t1 = {16'd0, temp_cal_ff[15:0]};
      coef.t2 = 32'(ptc_pkg::sext16(temp_cal_ff[31:16]));
      coef.t3 = 32'(ptc_pkg::sext16(temp_cal_ff[47:32]));
      coef.p1 = {48'd0, press_cal_a_ff[15:0]};
      coef.p2 = ptc_pkg::sext16(press_cal_a_ff[31:16]);
      coef.p3 = ptc_pkg::sext16(press_cal_a_ff[47:32]);
      coef.p4 = ptc_pkg::sext16(press_cal_a_ff[63:48]);
      coef.p5 = ptc_pkg::sext16(press_cal_b_ff[15:0]);
      coef.p6 = ptc_pkg::sext16(press_cal_b_ff[31:16]);
      coef.p7 = ptc_pkg::sext16(press_cal_b_ff[47:32]);
      coef.p8 = ptc_pkg::sext16(press_cal_b_ff[63:48]);
      coef.p9 = ptc_pkg::sext16(press_cal_c_ff);
   end

   assign busy = 1'b0;
   assign accept = start && !busy;

   ptc_front u_front (
      .clock(clock), .reset(reset), .in_valid(accept),
      .adc_temp(req_adc_temp), .adc_press(req_adc_press),
      .coef(coef), .div_req(div_req)
   );

   ptc_div u_div (
      .clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp)
   );

   ptc_back u_back (
      .clock(clock), .reset(reset), .coef(coef), .div_rsp(div_rsp),
      .out_valid(rsp_valid), .temperature(temp_w), .fine_temp(fine_w),
      .pressure(rsp_pressure), .divisor_zero(rsp_divisor_zero)
   );

   assign rsp_temperature = $signed(temp_w);
   assign rsp_fine_temp = $signed(fine_w);

   // A transaction at the divider output appears as a result once it has passed the back registers b1, b2 and b3.
   a_div_to_rsp: assert property (@(posedge clock) disable iff (reset)
      div_rsp.valid |-> ##3 rsp_valid) else $error("result lost after divider");

   // A zero divisor always forces the pressure to zero.
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divisor_zero |-> rsp_pressure == 32'd0)
      else $error("pressure not cleared on zero divisor");

   // Temperature always follows from the fine value.
   a_temp_rel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature == ((rsp_fine_temp * 5 + 128) >>> 8))
      else $error("temperature inconsistent with fine value");

endmodule

[tb/pressure_temperature_compensation_tb.sv]
`timescale 1ns / 1ps
module pressure_temperature_compensation_tb;

   // Extra wait at the end of every drain, after the last expected result.
   localparam int DrainCycles = 100;

   typedef struct {
      logic signed [31:0] temperature;
      logic signed [31:0] fine_temp;
      logic [31:0]        pressure;
      logic               divisor_zero;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [19:0] req_adc_temp;
   logic [19:0] req_adc_press;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;
   logic        rsp_valid;
   logic signed [31:0] rsp_temperature;
   logic signed [31:0] rsp_fine_temp;
   logic [31:0] rsp_pressure;
   logic        rsp_divisor_zero;

   // Shadow copy of the calibration words, updated together with every write.
   logic [47:0] cal_temp;
   logic [63:0] cal_press_a;
   logic [63:0] cal_press_b;
   logic [15:0] cal_press_c;

   reading_type expected_readings[$];
   int  error_count = 0;
   bit  idle_enable = 1'b1;

   pressure_temperature_compensation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_adc_temp(req_adc_temp), .req_adc_press(req_adc_press),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_temperature(rsp_temperature),
      .rsp_fine_temp(rsp_fine_temp), .rsp_pressure(rsp_pressure),
      .rsp_divisor_zero(rsp_divisor_zero)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Computes the compensated reading for one raw pair with the current calibration.
   // The temperature path wraps at 32 bits and the pressure path at 64 bits; the
   // arithmetic right shift operator on signed vectors gives the floor shift needed.
   function automatic reading_type compensate(input logic [19:0] adc_t,
                                              input logic [19:0] adc_p);
      reading_type r;
      logic signed [31:0] t1, t2, t3, x, d, fine, tmp;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, num, q, ps, c1, c2, pr;
      logic [63:0] mag_n, mag_d, mag_q;
      t1 = {16'd0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      x = (($signed({12'd0, adc_t} >> 3) - (t1 << 1)) * t2) >>> 11;
      d = ({12'd0, adc_t} >> 4) - t1;
      fine = x + ((((d * d) >>> 12) * t3) >>> 14);
      tmp = (fine * 32'sd5 + 32'sd128) >>> 8;

      p1 = {48'd0, cal_press_a[15:0]};
      p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
      p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
      p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
      p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
      p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
      p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
      p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
      p9 = {{48{cal_press_c[15]}}, cal_press_c};

      v1 = 64'(fine) - 64'sd128000;
      v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

      r.temperature = tmp;
      r.fine_temp = fine;
      r.pressure = '0;
      r.divisor_zero = (v1 == 0);
      if (v1 != 0) begin
         num = ((64'(64'd1048576 - {44'd0, adc_p}) << 31) - v2) * 64'sd3125;
         // Signed division on magnitudes, truncating toward zero and wrapping.
         mag_n = num[63] ? -num : num;
         mag_d = v1[63] ? -v1 : v1;
         mag_q = mag_n / mag_d;
         q = (num[63] != v1[63]) ? -mag_q : mag_q;
         ps = q >>> 13;
         c1 = (p9 * ps * ps) >>> 25;
         c2 = (p8 * q) >>> 19;
         pr = ((q + c1 + c2) >>> 8) + (p7 << 4);
         r.pressure = pr[31:0];
      end
      return r;
   endfunction

   // Every result is taken at the edge that ends its strobe cycle and is held against
   // the oldest expected reading.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_temperature !== want.temperature) begin
               $error("temperature: expected %0d, actual %0d", want.temperature,
                      rsp_temperature);
               error_count++;
            end
            if (rsp_fine_temp !== want.fine_temp) begin
               $error("fine_temp: expected %0d, actual %0d", want.fine_temp, rsp_fine_temp);
               error_count++;
            end
            if (rsp_pressure !== want.pressure) begin
               $error("pressure: expected %0h, actual %0h", want.pressure, rsp_pressure);
               error_count++;
            end
            if (rsp_divisor_zero !== want.divisor_zero) begin
               $error("divisor_zero: expected %0b, actual %0b", want.divisor_zero,
                      rsp_divisor_zero);
               error_count++;
            end
         end
      end
   end

   // Writes one calibration register while the block is idle and mirrors it.
   task automatic write_cal(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (index)
         ptc_pkg::CSR_TEMP_CAL: cal_temp = value[47:0];
         ptc_pkg::CSR_PRESS_CAL_A: cal_press_a = value;
         ptc_pkg::CSR_PRESS_CAL_B: cal_press_b = value;
         ptc_pkg::CSR_PRESS_CAL_C: cal_press_c = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all_cal(input logic [47:0] tc, input logic [63:0] pa,
                                input logic [63:0] pb, input logic [15:0] pc);
      write_cal(ptc_pkg::CSR_TEMP_CAL, {16'd0, tc});
      write_cal(ptc_pkg::CSR_PRESS_CAL_A, pa);
      write_cal(ptc_pkg::CSR_PRESS_CAL_B, pb);
      write_cal(ptc_pkg::CSR_PRESS_CAL_C, {48'd0, pc});
   endtask

   // Presents one reading pair and holds it until the block takes the transaction.
   // The caller is at a falling edge; start stays high across back-to-back items.
   task automatic send_reading(input logic [19:0] adc_t, input logic [19:0] adc_p);
      if (idle_enable) begin
         while ($urandom_range(99) < 6) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_adc_temp <= adc_t;
      req_adc_press <= adc_p;
      do @(posedge clock); while (busy);
      expected_readings.push_back(compensate(adc_t, adc_p));
      @(negedge clock);
   endtask

   // Drops start at once and waits for every outstanding result plus the latency margin.
   task automatic drain;
      start <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Zero calibration makes the divisor zero, so the flag and the forced zero show up.
   task automatic test_zero_divisor;
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      drain();
   endtask

   // Typical factory coefficients with field extremes on the raw inputs.
   task automatic test_typical_cal;
      write_all_cal({16'hFC18, 16'h6A5C, 16'h6E8B},
                    {16'h0F70, 16'h2A3B, 16'hD3D0, 16'h8F2C},
                    {16'h1770, 16'hC3FD, 16'hFFF9, 16'h008C}, 16'h1770);
      send_reading(20'd0, 20'd0);
      send_reading(20'hFFFFF, 20'd0);
      send_reading(20'd0, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'h7E000, 20'h65000);
      send_reading(20'h80000, 20'h80000);
      send_reading(20'h55555, 20'hAAAAA);
      send_reading(20'hAAAAA, 20'h55555);
      drain();
   endtask

   // All-ones, most-negative and most-positive coefficient words drive the products to their extremes.
   task automatic test_extreme_cal;
      write_all_cal('1, '1, '1, '1);
      send_reading(20'h00000, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'h00000);
      send_reading(20'h12345, 20'h6789A);
      drain();
      write_all_cal({16'h8000, 16'h8000, 16'hFFFF},
                    {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                    {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'h3C3C3, 20'hC3C3C);
      drain();
      write_all_cal({16'h7FFF, 16'h7FFF, 16'h0000},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                    {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
      send_reading(20'h00001, 20'h00001);
      send_reading(20'hFFFFE, 20'hFFFFE);
      drain();
   endtask

   // Random readings under several random calibrations; most sets stay near
   // plausible factory values so the divisor is seldom zero, the rest are raw noise.
   task automatic test_random_readings;
      for (int set = 0; set < 12; set++) begin
         if (set % 3 == 2) begin
            write_all_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom));
         end else begin
            write_all_cal({16'($urandom), 16'($urandom_range(28000, 24000)),
                           16'($urandom_range(29000, 26000))},
                          {16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(40000, 32000))},
                          {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                          16'($urandom));
         end
         // The middle sets send back to back with no idling at all.
         idle_enable = !(set == 5 || set == 6);
         for (int n = 0; n < 75; n++) begin
            send_reading(20'($urandom), 20'($urandom));
            // Once, the sender holds off until the pipeline has emptied.
            if (set == 3 && n == 30) begin
               start <= 1'b0;
               while (expected_readings.size() != 0) @(negedge clock);
            end
         end
         idle_enable = 1'b1;
         drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_adc_temp = '0;
      req_adc_press = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      cal_press_c = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_zero_divisor();
      test_typical_cal();
      test_extreme_cal();
      test_random_readings();

      if (error_count == 0) begin
         $display("pressure_temperature_compensation_tb: PASS");
      end else begin
         $display("pressure_temperature_compensation_tb: FAIL");
      end
      $finish;
   end

   // About a thousand items plus drains fit well inside this.
   initial begin
      #400000;
      $display("pressure_temperature_compensation_tb: FAIL");
      $finish;
   end

endmodule
